// ----- src/priority_inheritance_lock_manager_macros.svh -----
// Assertion macros for the priority-inheritance lock manager.
// Used by priority_inheritance_lock_manager.sv; expects clk and rst_n in scope.
`ifndef PRIORITY_INHERITANCE_LOCK_MANAGER_MACROS_SVH
`define PRIORITY_INHERITANCE_LOCK_MANAGER_MACROS_SVH

// Checked while out of reset.
`define PILM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PILM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/pilm_pkg.sv -----
// Types and codes for the priority-inheritance lock manager.
// No dependencies; used by priority_inheritance_lock_manager.sv.
package pilm_pkg;

    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_GET     = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_SETPRIO = 2'd3;

    localparam logic [3:0] ST_GRANTED  = 4'd0;
    localparam logic [3:0] ST_BLOCKED  = 4'd1;
    localparam logic [3:0] ST_FREED    = 4'd2;
    localparam logic [3:0] ST_XFER     = 4'd3;
    localparam logic [3:0] ST_BAD_RES  = 4'd4;
    localparam logic [3:0] ST_NO_TASK  = 4'd5;
    localparam logic [3:0] ST_NESTED   = 4'd6;
    localparam logic [3:0] ST_NOT_OWN  = 4'd7;
    localparam logic [3:0] ST_PRIO_SET = 4'd8;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] resource;
        logic [3:0] task_req;
        logic       task_present;
        logic [7:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [3:0] status;
        logic [3:0] affected_task;
        logic       affected_valid;
        logic [7:0] new_priority;
        logic [7:0] restored_priority;
        logic       restored_valid;
        logic       schedule_request;
    } rsp_t;

    // all-zero entry: unlocked, no waiter
    typedef struct packed {
        logic       locked;
        logic [3:0] owner;
        logic       waiter_valid;
        logic [3:0] waiter;
    } res_entry_t;

    // all-zero entry: priority 0, not boosted
    typedef struct packed {
        logic [7:0] prio;
        logic [7:0] saved;
        logic       boosted;
    } task_entry_t;

endpackage

// ----- src/priority_inheritance_lock_manager.sv -----
// Priority-inheritance lock manager: each command item passes through read and execute steps, and
// waits at its execute step while the previous response item is still waiting at rsp. The
// task entry of the owner or waiter can only be read once the resource entry has come out of its
// memory, so the two task-table reads are serialized.
// Both tables reset to empty at once through per-entry valid bits; no clearing pass is needed.
// One response item follows every command item, in order.
//
// Top level of the lock manager; depends on pilm_pkg and
// priority_inheritance_lock_manager_macros.svh.
`include "priority_inheritance_lock_manager_macros.svh"

module priority_inheritance_lock_manager #(
    parameter int RESOURCES = 16,
    parameter int TASKS     = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  pilm_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pilm_pkg::rsp_t rsp
);

    localparam int RES_AW  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int TASK_AW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam logic [5:0] RES_LIMIT  = 6'(RESOURCES);
    localparam logic [4:0] TASK_LIMIT = 5'(TASKS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;
    pilm_pkg::cmd_t item_reg;
    pilm_pkg::task_entry_t prio_t_reg;
    pilm_pkg::rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg;

    pilm_pkg::res_entry_t res_mem [RESOURCES];
    logic [RESOURCES-1:0] res_vld_reg;
    pilm_pkg::res_entry_t res_rdata_reg;
    logic res_rvld_reg;
    pilm_pkg::res_entry_t res_q;
    logic res_we;
    pilm_pkg::res_entry_t res_wdata;

    pilm_pkg::task_entry_t tp_mem [TASKS];
    logic [TASKS-1:0] tp_vld_reg;
    pilm_pkg::task_entry_t tp_rdata_reg;
    logic tp_rvld_reg;
    pilm_pkg::task_entry_t tp_q;
    logic tp_re;
    logic [3:0] tp_rsel;
    logic [3:0] tp_raddr;
    logic tp_we;
    logic [3:0] tp_waddr;
    pilm_pkg::task_entry_t tp_wdata;

    logic [TASKS-1:0] blocked_reg;
    logic blk_we;
    logic [3:0] blk_waddr;
    logic blk_wdata;

    logic accept;
    logic exec_go;
    logic res_ok;
    logic task_ok;
    logic rsp_is_release;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign res_q = res_rvld_reg ? res_rdata_reg : '0;
    assign tp_q  = tp_rvld_reg ? tp_rdata_reg : '0;

    assign res_ok  = ({1'b0, item_reg.resource} < RES_LIMIT);
    assign task_ok = ({1'b0, item_reg.task_req} < TASK_LIMIT);

    assign rsp_is_release = (rsp.status == pilm_pkg::ST_FREED) ||
                            (rsp.status == pilm_pkg::ST_XFER);

    // second task read: owner on get, waiter on release
    assign tp_rsel  = (item_reg.command == pilm_pkg::CMD_GET) ? res_q.owner : res_q.waiter;
    assign tp_re    = accept || (state_reg == S_READ);
    assign tp_raddr = accept ? cmd.task_req : tp_rsel;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:  if (exec_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            res_vld_reg   <= '0;
            tp_vld_reg    <= '0;
            blocked_reg   <= '0;
            res_rvld_reg  <= 1'b0;
            tp_rvld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            if (res_we)
                res_vld_reg[item_reg.resource[RES_AW-1:0]] <= 1'b1;
            if (tp_we)
                tp_vld_reg[tp_waddr[TASK_AW-1:0]] <= 1'b1;
            if (blk_we)
                blocked_reg[blk_waddr[TASK_AW-1:0]] <= blk_wdata;
            if (accept)
                res_rvld_reg <= res_vld_reg[cmd.resource[RES_AW-1:0]];
            if (tp_re)
                tp_rvld_reg <= tp_vld_reg[tp_raddr[TASK_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[item_reg.resource[RES_AW-1:0]] <= res_wdata;
        if (accept)
            res_rdata_reg <= res_mem[cmd.resource[RES_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (tp_we)
            tp_mem[tp_waddr[TASK_AW-1:0]] <= tp_wdata;
        if (tp_re)
            tp_rdata_reg <= tp_mem[tp_raddr[TASK_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= cmd;
        if (state_reg == S_READ)
            prio_t_reg <= tp_q;
        if (exec_go)
            rsp_reg <= rsp_next;
    end

    // command execution; tp_q holds the owner's or waiter's entry here
    always_comb
    begin
        rsp_next  = '0;
        res_we    = 1'b0;
        res_wdata = res_q;
        tp_we     = 1'b0;
        tp_waddr  = item_reg.task_req;
        tp_wdata  = prio_t_reg;
        blk_we    = 1'b0;
        blk_waddr = item_reg.task_req;
        blk_wdata = 1'b0;

        priority if (item_reg.command == pilm_pkg::CMD_SETPRIO)
        begin
            if (task_ok)
            begin
                tp_we = 1'b1;
                tp_wdata.prio = item_reg.priority_req;
                rsp_next.status = pilm_pkg::ST_PRIO_SET;
            end
            else
                rsp_next.status = pilm_pkg::ST_NO_TASK;
        end
        else if (!res_ok)
            rsp_next.status = pilm_pkg::ST_BAD_RES;
        else if (item_reg.command == pilm_pkg::CMD_INIT)
        begin
            res_we = 1'b1;
            res_wdata = '0;
            rsp_next.status = pilm_pkg::ST_FREED;
        end
        else if (!item_reg.task_present || !task_ok)
            rsp_next.status = pilm_pkg::ST_NO_TASK;
        else if (item_reg.command == pilm_pkg::CMD_GET)
        begin
            if (!res_q.locked)
            begin
                res_we = 1'b1;
                res_wdata = '0;
                res_wdata.locked = 1'b1;
                res_wdata.owner = item_reg.task_req;
                rsp_next.status = pilm_pkg::ST_GRANTED;
            end
            else if (res_q.owner == item_reg.task_req)
                rsp_next.status = pilm_pkg::ST_NESTED;
            else
            begin
                if (prio_t_reg.prio < tp_q.prio)
                begin
                    tp_we = 1'b1;
                    tp_waddr = res_q.owner;
                    tp_wdata.prio = prio_t_reg.prio;
                    tp_wdata.saved = tp_q.boosted ? tp_q.saved : tp_q.prio;
                    tp_wdata.boosted = 1'b1;
                    rsp_next.affected_task = res_q.owner;
                    rsp_next.affected_valid = 1'b1;
                    rsp_next.new_priority = prio_t_reg.prio;
                end
                res_we = 1'b1;
                res_wdata.waiter_valid = 1'b1;
                res_wdata.waiter = item_reg.task_req;
                blk_we = 1'b1;
                blk_wdata = 1'b1;
                rsp_next.status = pilm_pkg::ST_BLOCKED;
            end
        end
        else
        begin
            if (!res_q.locked || res_q.owner != item_reg.task_req)
                rsp_next.status = pilm_pkg::ST_NOT_OWN;
            else
            begin
                if (prio_t_reg.boosted)
                begin
                    tp_we = 1'b1;
                    tp_wdata.prio = prio_t_reg.saved;
                    tp_wdata.boosted = 1'b0;
                    rsp_next.restored_priority = prio_t_reg.saved;
                    rsp_next.restored_valid = 1'b1;
                end
                res_we = 1'b1;
                if (res_q.waiter_valid && blocked_reg[res_q.waiter[TASK_AW-1:0]])
                begin
                    res_wdata = '0;
                    res_wdata.locked = 1'b1;
                    res_wdata.owner = res_q.waiter;
                    blk_we = 1'b1;
                    blk_waddr = res_q.waiter;
                    blk_wdata = 1'b0;
                    rsp_next.affected_task = res_q.waiter;
                    rsp_next.affected_valid = 1'b1;
                    rsp_next.new_priority = tp_q.prio;
                    rsp_next.status = pilm_pkg::ST_XFER;
                end
                else
                begin
                    res_wdata = '0;
                    rsp_next.status = pilm_pkg::ST_FREED;
                end
                rsp_next.schedule_request = 1'b1;
            end
        end

        if (!exec_go)
        begin
            res_we = 1'b0;
            tp_we  = 1'b0;
            blk_we = 1'b0;
        end
    end

    `PILM_ASSERT(a_accept_to_exec, accept |-> ##2 (state_reg == S_EXEC), "item lost before execute")
    `PILM_ASSERT(a_rsp_from_exec, $rose(rsp_valid) |-> ($past(state_reg) == S_EXEC), "bad rsp raise")
    `PILM_ASSERT(a_writes_in_exec, (res_we || tp_we || blk_we) |-> exec_go, "write outside execute")
    `PILM_ASSERT(a_sched_status, (rsp_valid && rsp.schedule_request) |-> rsp_is_release, "stray sched")
    `PILM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!rsp_valid && state_reg == S_IDLE), "busy in reset")

endmodule

// ----- bench/priority_inheritance_lock_manager_tb.sv -----
// Self-checking bench for the priority-inheritance lock manager: a directed table, then
// random lock traffic, checked against a behavioral model of the lock and task tables.
// Depends on pilm_pkg and priority_inheritance_lock_manager.
module priority_inheritance_lock_manager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pilm_pkg::*;

    localparam int NRES         = 16;
    localparam int NTASK        = 16;
    localparam int RAND_ITEMS   = 233;
    localparam int LIMIT_CYCLES = 200000;
    localparam logic [4:0] NO_ID = 5'd31;

    typedef struct packed {
        cmd_t       c;
        logic       typed;
        logic [3:0] st;
    } dir_row_t;

    localparam int NDIR = 24;

    // typed = 1: result is status alone, all other fields zero
    dir_row_t dir_rows [NDIR] = '{
        {CMD_SETPRIO, 5'd0,  4'd15, 1'b1, 8'd255, 1'b1, ST_PRIO_SET},
        {CMD_SETPRIO, 5'd0,  4'd0,  1'b0, 8'd0,   1'b1, ST_PRIO_SET},
        {CMD_SETPRIO, 5'd0,  4'd3,  1'b1, 8'd10,  1'b1, ST_PRIO_SET},
        {CMD_SETPRIO, 5'd0,  4'd4,  1'b1, 8'd5,   1'b1, ST_PRIO_SET},
        {CMD_INIT,    5'd31, 4'd0,  1'b1, 8'd0,   1'b1, ST_BAD_RES},
        {CMD_GET,     5'd16, 4'd1,  1'b1, 8'd0,   1'b1, ST_BAD_RES},
        {CMD_RELEASE, 5'd31, 4'd1,  1'b1, 8'd0,   1'b1, ST_BAD_RES},
        {CMD_GET,     5'd0,  4'd1,  1'b0, 8'd0,   1'b1, ST_NO_TASK},
        {CMD_RELEASE, 5'd0,  4'd1,  1'b0, 8'd0,   1'b1, ST_NO_TASK},
        {CMD_RELEASE, 5'd0,  4'd3,  1'b1, 8'd0,   1'b1, ST_NOT_OWN},
        {CMD_GET,     5'd0,  4'd15, 1'b1, 8'd0,   1'b1, ST_GRANTED},
        {CMD_GET,     5'd0,  4'd15, 1'b1, 8'd0,   1'b1, ST_NESTED},
        {CMD_GET,     5'd0,  4'd3,  1'b1, 8'd0,   1'b0, ST_GRANTED},
        {CMD_GET,     5'd0,  4'd4,  1'b1, 8'd0,   1'b0, ST_GRANTED},
        {CMD_GET,     5'd15, 4'd0,  1'b1, 8'd0,   1'b1, ST_GRANTED},
        {CMD_SETPRIO, 5'd0,  4'd15, 1'b1, 8'd200, 1'b1, ST_PRIO_SET},
        {CMD_GET,     5'd15, 4'd4,  1'b1, 8'd0,   1'b0, ST_GRANTED},
        {CMD_RELEASE, 5'd0,  4'd15, 1'b1, 8'd0,   1'b0, ST_GRANTED},
        {CMD_RELEASE, 5'd15, 4'd0,  1'b1, 8'd0,   1'b0, ST_GRANTED},
        {CMD_INIT,    5'd0,  4'd0,  1'b1, 8'd0,   1'b1, ST_FREED},
        {CMD_GET,     5'd1,  4'd3,  1'b1, 8'd0,   1'b1, ST_GRANTED},
        {CMD_GET,     5'd2,  4'd3,  1'b1, 8'd0,   1'b1, ST_GRANTED},
        {CMD_GET,     5'd1,  4'd4,  1'b1, 8'd0,   1'b0, ST_GRANTED},
        {CMD_RELEASE, 5'd2,  4'd3,  1'b1, 8'd0,   1'b0, ST_GRANTED}
    };

    logic clk;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic       lk_locked  [NRES];
    logic [4:0] lk_owner   [NRES];
    logic [4:0] lk_waiter  [NRES];
    logic [7:0] tk_prio    [NTASK];
    logic [7:0] tk_saved   [NTASK];
    logic       tk_boosted [NTASK];
    logic       tk_blocked [NTASK];

    rsp_t lock_rsp_q [$];
    int   errors        = 0;
    int   cycles        = 0;
    int   send_idle_pct = 12;
    int   rsp_stall_pct = 79;

    priority_inheritance_lock_manager #(
        .RESOURCES(NRES),
        .TASKS    (NTASK)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic rsp_t predict_lock_step(input cmd_t c);
        rsp_t       o;
        logic [4:0] own;
        logic [4:0] w;
        int         r;
        int         t;
        o = '0;
        r = c.resource;
        t = c.task_req;
        if (c.command == CMD_SETPRIO)
        begin
            tk_prio[t] = c.priority_req;
            o.status = ST_PRIO_SET;
        end
        else if (r >= NRES)
            o.status = ST_BAD_RES;
        else if (c.command == CMD_INIT)
        begin
            lk_locked[r] = 1'b0;
            lk_owner[r]  = NO_ID;
            lk_waiter[r] = NO_ID;
            o.status = ST_FREED;
        end
        else if (!c.task_present)
            o.status = ST_NO_TASK;
        else if (c.command == CMD_GET)
        begin
            if (!lk_locked[r])
            begin
                lk_locked[r] = 1'b1;
                lk_owner[r]  = 5'(t);
                lk_waiter[r] = NO_ID;
                o.status = ST_GRANTED;
            end
            else if (lk_owner[r] == 5'(t))
                o.status = ST_NESTED;
            else
            begin
                own = lk_owner[r];
                if (own < NTASK && tk_prio[t] < tk_prio[own[3:0]])
                begin
                    if (!tk_boosted[own[3:0]])
                    begin
                        tk_saved[own[3:0]]   = tk_prio[own[3:0]];
                        tk_boosted[own[3:0]] = 1'b1;
                    end
                    tk_prio[own[3:0]] = tk_prio[t];
                    o.affected_task  = own[3:0];
                    o.affected_valid = 1'b1;
                    o.new_priority   = tk_prio[t];
                end
                lk_waiter[r]  = 5'(t);
                tk_blocked[t] = 1'b1;
                o.status = ST_BLOCKED;
            end
        end
        else if (lk_owner[r] != 5'(t))
            o.status = ST_NOT_OWN;
        else
        begin
            w = lk_waiter[r];
            if (tk_boosted[t])
            begin
                tk_prio[t]    = tk_saved[t];
                tk_boosted[t] = 1'b0;
                o.restored_priority = tk_saved[t];
                o.restored_valid    = 1'b1;
            end
            if (w < NTASK && tk_blocked[w[3:0]])
            begin
                lk_owner[r]  = w;
                lk_waiter[r] = NO_ID;
                tk_blocked[w[3:0]] = 1'b0;
                o.affected_task  = w[3:0];
                o.affected_valid = 1'b1;
                o.new_priority   = tk_prio[w[3:0]];
                o.status = ST_XFER;
            end
            else
            begin
                lk_locked[r] = 1'b0;
                lk_owner[r]  = NO_ID;
                lk_waiter[r] = NO_ID;
                o.status = ST_FREED;
            end
            o.schedule_request = 1'b1;
        end
        return o;
    endfunction

    // mostly contended traffic on a few resources and tasks; releases favor the owner
    function automatic cmd_t random_lock_cmd();
        cmd_t c;
        int   sel;
        sel = $urandom_range(99);
        c.command = (sel < 40) ? CMD_GET : (sel < 75) ? CMD_RELEASE :
                    (sel < 92) ? CMD_SETPRIO : CMD_INIT;
        c.resource = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
        c.task_req = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
        c.task_present = ($urandom_range(19) != 0);
        c.priority_req = 8'($urandom);
        if (c.command == CMD_RELEASE && c.resource < NRES && lk_locked[c.resource]
            && $urandom_range(3) != 0)
            c.task_req = lk_owner[c.resource][3:0];
        return c;
    endfunction

    task automatic send_item(input cmd_t c, input logic typed, input logic [3:0] st);
        rsp_t expected;
        rsp_t typed_rsp;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        expected = predict_lock_step(c);
        typed_rsp = '0;
        typed_rsp.status = st;
        lock_rsp_q.push_back(typed ? typed_rsp : expected);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : rsp_monitor
        rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (lock_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $realtime, rsp);
                errors++;
            end
            else
            begin
                exp_rsp = lock_rsp_q.pop_front();
                check_field("status", exp_rsp.status, rsp.status);
                check_field("affected_task", exp_rsp.affected_task, rsp.affected_task);
                check_field("affected_valid", exp_rsp.affected_valid, rsp.affected_valid);
                check_field("new_priority", exp_rsp.new_priority, rsp.new_priority);
                check_field("restored_priority", exp_rsp.restored_priority,
                            rsp.restored_priority);
                check_field("restored_valid", exp_rsp.restored_valid, rsp.restored_valid);
                check_field("schedule_request", exp_rsp.schedule_request,
                            rsp.schedule_request);
            end
        end
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    initial
    begin : stimulus
        int i;
        int ph;
        for (i = 0; i < NRES; i++)
        begin
            lk_locked[i] = 1'b0;
            lk_owner[i]  = NO_ID;
            lk_waiter[i] = NO_ID;
        end
        for (i = 0; i < NTASK; i++)
        begin
            tk_prio[i]    = '0;
            tk_saved[i]   = '0;
            tk_boosted[i] = 1'b0;
            tk_blocked[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NDIR; i++)
            send_item(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].st);

        for (ph = 0; ph < 3; ph++)
        begin
            // drain between phases
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while (lock_rsp_q.size() != 0);
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 79 : 0;
            rsp_stall_pct = (ph == 0) ? 79 : (ph == 1) ? 12 : 0;
            for (i = 0; i < RAND_ITEMS; i++)
                send_item(random_lock_cmd(), 1'b0, ST_GRANTED);
        end

        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (lock_rsp_q.size() != 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
